// ===== rtl/mlp_pkg.sv =====
package mlp_pkg;

    localparam int SCREEN_WIDTH = 128;
    localparam int MAX_ROWS     = 64;
    localparam int STORE_DEPTH  = 1024;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int PAGE_BITS    = 8;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BITS);
    localparam int COORD_W      = 10;
    localparam int INDEX_W      = 10;
    localparam int ROWS_W       = 7;
    localparam int COLOR_W      = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_INDEX_W  = 1;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int ERR_W        = COORD_W + 3;
    localparam int CALC_W       = 14;

    localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_ROWS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_COLOR = 1'd1;

    localparam logic [COLOR_W-1:0] COLOR_SET    = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_CLEAR  = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_TOGGLE = 2'd2;

    typedef enum logic [1:0] {
        ACT_LINE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LINE,
        ST_DRAIN,
        ST_CLEAR,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } walk_cmd_t;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pixel_t;

endpackage

// ===== rtl/mlp_req_if.sv =====
interface mlp_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         action;
    logic signed [mlp_pkg::COORD_W-1:0] x_start;
    logic signed [mlp_pkg::COORD_W-1:0] y_start;
    logic signed [mlp_pkg::COORD_W-1:0] x_end;
    logic signed [mlp_pkg::COORD_W-1:0] y_end;
    logic [mlp_pkg::INDEX_W-1:0]        byte_index;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end, byte_index,
        input  ready
    );

    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end, byte_index,
        output ready
    );
endinterface

// ===== rtl/mlp_rsp_if.sv =====
interface mlp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       index_ok;

    modport source (
        output valid, read_data, index_ok,
        input  ready
    );

    modport sink (
        input  valid, read_data, index_ok,
        output ready
    );
endinterface

// ===== rtl/mlp_frame_ram.sv =====
module mlp_frame_ram (
    input  logic                                clk,
    input  logic                                we,
    input  logic [mlp_pkg::ADDR_W-1:0]          waddr,
    input  logic [mlp_pkg::PAGE_BITS-1:0]       wdata,
    input  logic [mlp_pkg::ADDR_W-1:0]          raddr,
    output logic [mlp_pkg::PAGE_BITS-1:0]       rdata
);

    logic [mlp_pkg::PAGE_BITS-1:0] mem [mlp_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mlp_line_walker.sv =====
module mlp_line_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  mlp_pkg::walk_cmd_t  cmd,
    output mlp_pkg::pixel_t     pix
);

    localparam int CW = mlp_pkg::COORD_W;
    localparam int DW = mlp_pkg::DIFF_W;
    localparam int EW = mlp_pkg::ERR_W;

    logic                 busy_reg, busy_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] xe_reg, xe_next;
    logic signed [CW-1:0] ye_reg, ye_next;
    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic                 sx_neg_reg, sx_neg_next;
    logic                 sy_neg_reg, sy_neg_next;
    logic signed [EW-1:0] err_reg, err_next;

    logic signed [DW-1:0] x0_ext, x1_ext, y0_ext, y1_ext;
    logic signed [EW:0]   e2;
    logic signed [EW:0]   dx_cmp, dy_cmp;
    logic signed [EW-1:0] dx_err, dy_err;
    logic                 at_end, step_x, step_y;

    always_comb
    begin
        x0_ext = $signed({cmd.x0[CW-1], cmd.x0});
        x1_ext = $signed({cmd.x1[CW-1], cmd.x1});
        y0_ext = $signed({cmd.y0[CW-1], cmd.y0});
        y1_ext = $signed({cmd.y1[CW-1], cmd.y1});

        dx_err = $signed({{(EW-DW){dx_reg[DW-1]}}, dx_reg});
        dy_err = $signed({{(EW-DW){dy_reg[DW-1]}}, dy_reg});
        dx_cmp = $signed({dx_err[EW-1], dx_err});
        dy_cmp = $signed({dy_err[EW-1], dy_err});
        e2     = $signed({err_reg, 1'b0});
        at_end = (x_reg == xe_reg) && (y_reg == ye_reg);
        step_x = e2 >= dy_cmp;
        step_y = e2 <= dx_cmp;

        busy_next   = busy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        xe_next     = xe_reg;
        ye_next     = ye_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;

        if (cmd.start)
        begin
            busy_next   = 1'b1;
            x_next      = cmd.x0;
            y_next      = cmd.y0;
            xe_next     = cmd.x1;
            ye_next     = cmd.y1;
            dx_next     = (x1_ext > x0_ext) ? (x1_ext - x0_ext) : (x0_ext - x1_ext);
            dy_next     = (y1_ext > y0_ext) ? (y0_ext - y1_ext) : (y1_ext - y0_ext);
            sx_neg_next = !(cmd.x0 < cmd.x1);
            sy_neg_next = !(cmd.y0 < cmd.y1);
            err_next    = $signed({{(EW-DW){dx_next[DW-1]}}, dx_next})
                        + $signed({{(EW-DW){dy_next[DW-1]}}, dy_next});
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                err_next = err_reg + (step_x ? dy_err : '0) + (step_y ? dx_err : '0);
                if (step_x)
                begin
                    x_next = sx_neg_reg ? (x_reg - CW'(1)) : (x_reg + CW'(1));
                end
                if (step_y)
                begin
                    y_next = sy_neg_reg ? (y_reg - CW'(1)) : (y_reg + CW'(1));
                end
            end
        end

        pix.valid = busy_reg;
        pix.last  = at_end;
        pix.x     = x_reg;
        pix.y     = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
    end

endmodule

// ===== rtl/mono_line_plotter_core.sv =====
// Read request: the addressed store byte is registered into the response output, held while an earlier response waits.
// Line request: one pixel per cycle through the frame RAM read-modify-write
//   pipeline; the next request is accepted after the ST_DRAIN state.
// Clear request: one store byte written per cycle until all 1024 are zeroed.
// Reset: a clearing sweep over all 1024 bytes zeroes the store; no request is
//   accepted until it ends, configuration writes are taken throughout.
module mono_line_plotter_core (
    input  logic                               clk,
    input  logic                               rst_n,
    mlp_req_if.sink                            req,
    mlp_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [mlp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = mlp_pkg::ADDR_W;
    localparam int PB = mlp_pkg::PAGE_BITS;
    localparam int CW = mlp_pkg::CALC_W;
    localparam int RW = mlp_pkg::ROWS_W;

    mlp_pkg::state_t            state_reg, state_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]              panel_rows_reg;
    logic [mlp_pkg::COLOR_W-1:0] draw_color_reg;
    logic [AW-1:0]              rd_addr_reg, rd_addr_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic                       s1_valid_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic [PB-1:0]              s1_mask_reg;
    logic                       fw_valid_reg;
    logic [AW-1:0]              fw_addr_reg;
    logic [PB-1:0]              fw_data_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [PB-1:0]              out_data_reg;
    logic                       out_ok_reg;
    logic                       out_load;

    mlp_pkg::walk_cmd_t         walk_cmd;
    mlp_pkg::pixel_t            pix;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [PB-1:0]              ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [PB-1:0]              ram_rdata;

    logic                       req_accept;
    logic [RW-1:0]              active_rows;
    logic [CW-1:0]              read_pages;
    logic [CW-1:0]              read_limit;
    logic [CW-1:0]              req_idx;
    logic                       req_idx_ok;
    logic [CW-1:0]              x_u, y_u, pix_idx;
    logic                       x_in, y_in, pix_ok;
    logic [PB-1:0]              pix_mask;
    logic [PB-1:0]              old_byte, new_byte;

    mlp_line_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (walk_cmd),
        .pix   (pix)
    );

    mlp_frame_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        active_rows = (panel_rows_reg > RW'(mlp_pkg::MAX_ROWS))
                    ? RW'(mlp_pkg::MAX_ROWS) : panel_rows_reg;
        read_pages  = (CW'(active_rows) + CW'(PB - 1)) >> mlp_pkg::PAGE_SHIFT;
        read_limit  = read_pages * CW'(mlp_pkg::SCREEN_WIDTH);
        req_idx     = CW'(req.byte_index);
        req_idx_ok  = (req_idx < read_limit) && (req_idx < CW'(mlp_pkg::STORE_DEPTH));

        x_u      = CW'($unsigned(pix.x));
        y_u      = CW'($unsigned(pix.y));
        x_in     = !pix.x[mlp_pkg::COORD_W-1] && (x_u < CW'(mlp_pkg::SCREEN_WIDTH));
        y_in     = !pix.y[mlp_pkg::COORD_W-1] && (y_u < CW'(active_rows));
        pix_idx  = ((y_u >> mlp_pkg::PAGE_SHIFT) * CW'(mlp_pkg::SCREEN_WIDTH)) + x_u;
        pix_ok   = pix.valid && x_in && y_in && (pix_idx < CW'(mlp_pkg::STORE_DEPTH));
        pix_mask = PB'(1) << y_u[mlp_pkg::PAGE_SHIFT-1:0];

        old_byte = (fw_valid_reg && (fw_addr_reg == s1_addr_reg)) ? fw_data_reg : ram_rdata;
        case (draw_color_reg)
            mlp_pkg::COLOR_SET:    new_byte = old_byte | s1_mask_reg;
            mlp_pkg::COLOR_CLEAR:  new_byte = old_byte & ~s1_mask_reg;
            mlp_pkg::COLOR_TOGGLE: new_byte = old_byte ^ s1_mask_reg;
            default:               new_byte = old_byte;
        endcase
    end

    always_comb
    begin
        req.ready  = (state_reg == mlp_pkg::ST_IDLE);
        req_accept = req.valid && req.ready;

        walk_cmd.start = req_accept && (mlp_pkg::action_t'(req.action) == mlp_pkg::ACT_LINE);
        walk_cmd.x0    = req.x_start;
        walk_cmd.y0    = req.y_start;
        walk_cmd.x1    = req.x_end;
        walk_cmd.y1    = req.y_end;

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        rd_ok_next     = rd_ok_reg;
        out_load       = 1'b0;

        ram_we    = s1_valid_reg;
        ram_waddr = s1_addr_reg;
        ram_wdata = new_byte;
        ram_raddr = req.byte_index;

        case (state_reg)
            mlp_pkg::ST_INIT, mlp_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(mlp_pkg::STORE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = mlp_pkg::ST_IDLE;
                end
            end
            mlp_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    case (mlp_pkg::action_t'(req.action))
                        mlp_pkg::ACT_LINE:
                        begin
                            state_next = mlp_pkg::ST_LINE;
                        end
                        mlp_pkg::ACT_READ:
                        begin
                            rd_addr_next = req.byte_index;
                            rd_ok_next   = req_idx_ok;
                            state_next   = mlp_pkg::ST_READ;
                        end
                        mlp_pkg::ACT_CLEAR:
                        begin
                            state_next = mlp_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = mlp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mlp_pkg::ST_LINE:
            begin
                ram_raddr = pix_idx[AW-1:0];
                if (pix.valid && pix.last)
                begin
                    state_next = mlp_pkg::ST_DRAIN;
                end
            end
            mlp_pkg::ST_DRAIN:
            begin
                state_next = mlp_pkg::ST_IDLE;
            end
            mlp_pkg::ST_READ:
            begin
                ram_raddr = rd_addr_reg;
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = mlp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlp_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !rsp.ready);

        rsp.valid     = out_valid_reg;
        rsp.read_data = out_data_reg;
        rsp.index_ok  = out_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mlp_pkg::ST_INIT;
            clr_cnt_reg    <= '0;
            panel_rows_reg <= RW'(64);
            draw_color_reg <= mlp_pkg::COLOR_SET;
            s1_valid_reg   <= 1'b0;
            fw_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= pix_ok;
            fw_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mlp_pkg::CFG_PANEL_ROWS: panel_rows_reg <= cfg_data[RW-1:0];
                    mlp_pkg::CFG_DRAW_COLOR: draw_color_reg <= cfg_data[mlp_pkg::COLOR_W-1:0];
                    default:                 panel_rows_reg <= panel_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        rd_ok_reg   <= rd_ok_next;
        s1_addr_reg <= pix_idx[AW-1:0];
        s1_mask_reg <= pix_mask;
        fw_addr_reg <= s1_addr_reg;
        fw_data_reg <= new_byte;
        if (out_load)
        begin
            out_data_reg <= rd_ok_reg ? ram_rdata : '0;
            out_ok_reg   <= rd_ok_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlp_pkg::ST_IDLE) |-> !ram_we)
        else $error("frame store written while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid |-> (state_reg == mlp_pkg::ST_LINE))
        else $error("pixel produced outside line drawing");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> ($past(state_reg) == mlp_pkg::ST_READ))
        else $error("response raised without a read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlp_pkg::ST_DRAIN) |-> !s1_valid_reg || $past(pix.last))
        else $error("pipeline write pending after line end");

endmodule
